// ----- hdl/tx_ring_packet_framer_dma_defines.svh -----
// Assertion macros shared by the transmit ring framer modules.
`ifndef TX_RING_PACKET_FRAMER_DMA_DEFINES_SVH
`define TX_RING_PACKET_FRAMER_DMA_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define TRPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger in one cycle leads to a condition in the next.
`define TRPF_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/trpf_pkg.sv -----
// Types, constants and helpers shared by the transmit ring framer.
`timescale 1ns / 1ps

package trpf_pkg;

    localparam int RING_BYTES  = 8192;
    localparam int ADDR_W      = 13;
    localparam int CNT_W       = 14;
    localparam int LEN_W       = 16;
    localparam int SPACE_W     = LEN_W + 1;
    localparam int HDR_BYTES   = 6;
    localparam int HDR_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] HDR_MAGIC_0 = 8'hBE;
    localparam logic [7:0] HDR_MAGIC_1 = 8'hEF;

    typedef enum logic [2:0] {
        CMD_PUT     = 3'd0,
        CMD_BEGIN   = 3'd1,
        CMD_PAYLOAD = 3'd2,
        CMD_DONE    = 3'd3,
        CMD_FETCH   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_NOSPACE = 2'd1,
        STS_SEQ     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_HEADER,
        OP_FETCH
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_HDR,
        BK_RESULT
    } back_state_t;

    typedef struct packed {
        status_t            status;
        logic [CNT_W-1:0]   free_space;
        logic               dma_start;
        logic [ADDR_W-1:0]  dma_offset;
        logic [CNT_W-1:0]   dma_length;
        logic               transferring;
    } result_t;

    typedef struct packed {
        op_t                op;
        logic [ADDR_W-1:0]  addr;
        logic [7:0]         data;
        logic [LEN_W-1:0]   plen;
        logic [7:0]         sock;
        result_t            res;
    } entry_t;

    // Fold a sum that is below twice the ring size back into the ring.
    function automatic logic [ADDR_W-1:0] ring_wrap(input logic [ADDR_W:0] s);
        logic [ADDR_W:0] r;
        r = s;
        if (s >= (ADDR_W+1)'(RING_BYTES))
        begin
            r = s - (ADDR_W+1)'(RING_BYTES);
        end
        return r[ADDR_W-1:0];
    endfunction

    // Advance a ring offset by a small step.
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                   input logic [HDR_IDX_W-1:0] step);
        return ring_wrap({1'b0, a} + (ADDR_W+1)'(step));
    endfunction

endpackage

// ----- hdl/trpf_ram.sv -----
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module trpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read; read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/trpf_queue.sv -----
// Short register queue of classified items between front and back.
`timescale 1ns / 1ps

module trpf_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  trpf_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             nonempty,
    output trpf_pkg::entry_t head_entry
);

    import trpf_pkg::*;

    entry_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign nonempty   = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- hdl/trpf_front.sv -----
// Front end: accepts items, checks space and sequence, keeps ring pointers.
`timescale 1ns / 1ps

module trpf_front #(
    parameter int MAX_CHUNK = 65535
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   command,
    input  logic [7:0]                   data_byte,
    input  logic [trpf_pkg::LEN_W-1:0]   packet_length,
    input  logic [7:0]                   socket_id,
    input  logic [trpf_pkg::ADDR_W-1:0]  fetch_address,
    input  logic                         q_full,
    output logic                         q_push,
    output trpf_pkg::entry_t             q_entry
);

    `include "tx_ring_packet_framer_dma_defines.svh"

    import trpf_pkg::*;

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [ADDR_W-1:0] tail_end_reg, tail_end_next;
    logic [CNT_W-1:0]  chunk_reg, chunk_next;
    logic [CNT_W-1:0]  free_reg, free_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic              busy_reg, busy_next;

    logic              accept;
    logic              launch;
    logic [CNT_W-1:0]  len_raw;
    logic [CNT_W-1:0]  len;
    status_t           status;
    op_t               op;
    logic [ADDR_W-1:0] entry_addr;
    logic              space_ok;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign space_ok = {{(SPACE_W-CNT_W){1'b0}}, free_reg} >
                      ({1'b0, packet_length} + SPACE_W'(HDR_BYTES + 3));

    // Classify the item and work out the pointer updates
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        free_next  = free_reg;
        rem_next   = rem_reg;
        busy_next  = busy_reg;
        chunk_next = chunk_reg;
        status     = STS_OK;
        op         = OP_NONE;
        entry_addr = head_reg;
        launch     = 1'b0;
        case (command)
            CMD_PUT:
            begin
                if (rem_reg != '0)
                begin
                    status = STS_SEQ;
                end
                else if (free_reg <= CNT_W'(2))
                begin
                    status = STS_NOSPACE;
                end
                else
                begin
                    op        = OP_WRITE;
                    head_next = ring_add(head_reg, HDR_IDX_W'(1));
                    free_next = free_reg - 1'b1;
                    launch    = !busy_reg;
                end
            end
            CMD_BEGIN:
            begin
                if (rem_reg != '0)
                begin
                    status = STS_SEQ;
                end
                else if (!space_ok)
                begin
                    status = STS_NOSPACE;
                end
                else
                begin
                    op        = OP_HEADER;
                    head_next = ring_add(head_reg, HDR_IDX_W'(HDR_BYTES));
                    free_next = free_reg - CNT_W'(HDR_BYTES);
                    rem_next  = packet_length;
                    launch    = (packet_length == '0) && !busy_reg;
                end
            end
            CMD_PAYLOAD:
            begin
                if (rem_reg == '0)
                begin
                    status = STS_SEQ;
                end
                else
                begin
                    op        = OP_WRITE;
                    head_next = ring_add(head_reg, HDR_IDX_W'(1));
                    free_next = free_reg - 1'b1;
                    rem_next  = rem_reg - 1'b1;
                    launch    = (rem_reg == LEN_W'(1)) && !busy_reg;
                end
            end
            CMD_DONE:
            begin
                if (!busy_reg)
                begin
                    status = STS_SEQ;
                end
                else
                begin
                    tail_next = tail_end_reg;
                    free_next = free_reg + chunk_reg;
                    if (head_reg != tail_end_reg)
                    begin
                        launch = 1'b1;
                    end
                    else
                    begin
                        busy_next  = 1'b0;
                        chunk_next = '0;
                    end
                end
            end
            CMD_FETCH:
            begin
                op         = OP_FETCH;
                entry_addr = fetch_address;
            end
            default:
            begin
                status = STS_SEQ;
            end
        endcase
        if (launch)
        begin
            busy_next  = 1'b1;
            chunk_next = len;
        end
    end

    // Size the chunk from the new tail up to the head or the ring end
    always_comb
    begin
        if (head_next >= tail_next)
        begin
            len_raw = {1'b0, head_next} - {1'b0, tail_next};
        end
        else
        begin
            len_raw = CNT_W'(RING_BYTES) - {1'b0, tail_next};
        end
        len = len_raw;
        if (32'(len_raw) > MAX_CHUNK)
        begin
            len = CNT_W'(MAX_CHUNK);
        end
        tail_end_next = tail_end_reg;
        if (launch)
        begin
            tail_end_next = ring_wrap({1'b0, tail_next} + len);
        end
    end

    // Build the queue item
    always_comb
    begin
        q_push                    = accept;
        q_entry.op                = op;
        q_entry.addr              = entry_addr;
        q_entry.data              = data_byte;
        q_entry.plen              = packet_length;
        q_entry.sock              = socket_id;
        q_entry.res.status        = status;
        q_entry.res.free_space    = free_next;
        q_entry.res.dma_start     = launch;
        q_entry.res.dma_offset    = launch ? tail_next : '0;
        q_entry.res.dma_length    = launch ? len : '0;
        q_entry.res.transferring  = busy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            tail_end_reg <= '0;
            chunk_reg    <= '0;
            free_reg     <= CNT_W'(RING_BYTES);
            rem_reg      <= '0;
            busy_reg     <= 1'b0;
        end
        else if (accept)
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            tail_end_reg <= tail_end_next;
            chunk_reg    <= chunk_next;
            free_reg     <= free_next;
            rem_reg      <= rem_next;
            busy_reg     <= busy_next;
        end
    end

    `TRPF_ASSERT(a_free_bounds,
        free_reg >= CNT_W'(2) && free_reg <= CNT_W'(RING_BYTES),
        "free space left its legal range")
    `TRPF_ASSERT(a_idle_no_chunk, !busy_reg |-> chunk_reg == '0,
        "chunk length held while no transfer is running")
    `TRPF_ASSERT_NEXT(a_drain_idle,
        accept && command == CMD_DONE && busy_reg && head_reg == tail_end_reg,
        !busy_reg && free_reg == CNT_W'(RING_BYTES),
        "ring not empty and idle after the last chunk retired")

endmodule

// ----- hdl/trpf_back.sv -----
// Back end: writes the ring, serves fetches, and holds the result register.
`timescale 1ns / 1ps

module trpf_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_nonempty,
    input  trpf_pkg::entry_t             q_entry,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output trpf_pkg::result_t            out_res,
    output logic [7:0]                   out_fetch
);

    `include "tx_ring_packet_framer_dma_defines.svh"

    import trpf_pkg::*;

    back_state_t          state_reg, state_next;
    entry_t               cur_reg;
    logic [HDR_IDX_W-1:0] hdr_idx_reg;
    logic [ADDR_W-1:0]    hdr_addr_reg;
    logic                 out_valid_reg;
    result_t              out_res_reg;
    logic [7:0]           out_fetch_reg;

    logic                 out_free;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [7:0]           ram_wdata;
    logic                 ram_re;
    logic [7:0]           ram_rdata;
    logic                 load_out;
    result_t              load_res;
    logic [7:0]           load_fetch;

    // Header byte at a given place of the six byte frame
    function automatic logic [7:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx,
                                            input logic [LEN_W-1:0] plen,
                                            input logic [7:0] sock);
        logic [7:0] b;
        case (idx)
            3'd0:    b = HDR_MAGIC_0;
            3'd1:    b = HDR_MAGIC_1;
            3'd2:    b = plen[7:0];
            3'd3:    b = plen[15:8];
            3'd5:    b = sock;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    assign out_free = !out_valid_reg || !out_stall;

    trpf_ram #(
        .WIDTH (8),
        .DEPTH (RING_BYTES)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (q_entry.addr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_nonempty)
                begin
                    case (q_entry.op)
                        OP_HEADER: state_next = BK_HDR;
                        OP_FETCH:  state_next = BK_RESULT;
                        default:   state_next = BK_IDLE;
                    endcase
                end
            end
            BK_HDR:
            begin
                if (hdr_idx_reg == HDR_IDX_W'(HDR_BYTES-1))
                begin
                    state_next = BK_RESULT;
                end
            end
            BK_RESULT:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Memory strobes, queue pop and result load
    always_comb
    begin
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = q_entry.addr;
        ram_wdata  = q_entry.data;
        ram_re     = 1'b0;
        load_out   = 1'b0;
        load_res   = q_entry.res;
        load_fetch = 8'h00;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_nonempty)
                begin
                    case (q_entry.op)
                        OP_WRITE:
                        begin
                            if (out_free)
                            begin
                                q_pop    = 1'b1;
                                ram_we   = 1'b1;
                                load_out = 1'b1;
                            end
                        end
                        OP_HEADER:
                        begin
                            q_pop     = 1'b1;
                            ram_we    = 1'b1;
                            ram_wdata = HDR_MAGIC_0;
                        end
                        OP_FETCH:
                        begin
                            q_pop  = 1'b1;
                            ram_re = 1'b1;
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                q_pop    = 1'b1;
                                load_out = 1'b1;
                            end
                        end
                    endcase
                end
            end
            BK_HDR:
            begin
                ram_we    = 1'b1;
                ram_waddr = hdr_addr_reg;
                ram_wdata = hdr_byte(hdr_idx_reg, cur_reg.plen, cur_reg.sock);
            end
            BK_RESULT:
            begin
                load_res   = cur_reg.res;
                load_fetch = (cur_reg.op == OP_FETCH) ? ram_rdata : 8'h00;
                load_out   = out_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the working item, header cursor and result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg      <= q_entry;
            hdr_idx_reg  <= HDR_IDX_W'(1);
            hdr_addr_reg <= ring_add(q_entry.addr, HDR_IDX_W'(1));
        end
        else if (state_reg == BK_HDR)
        begin
            hdr_idx_reg  <= hdr_idx_reg + 1'b1;
            hdr_addr_reg <= ring_add(hdr_addr_reg, HDR_IDX_W'(1));
        end
        if (load_out)
        begin
            out_res_reg   <= load_res;
            out_fetch_reg <= load_fetch;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_fetch = out_fetch_reg;

    `TRPF_ASSERT(a_pop_idle, q_pop |-> state_reg == BK_IDLE,
        "queue popped while an item is still in progress")
    `TRPF_ASSERT(a_hdr_cursor,
        state_reg == BK_HDR |-> hdr_idx_reg >= HDR_IDX_W'(1)
            && hdr_idx_reg <= HDR_IDX_W'(HDR_BYTES-1),
        "header cursor out of frame")
    `TRPF_ASSERT(a_result_no_write, state_reg == BK_RESULT |-> !ram_we && !q_pop,
        "ring written or queue popped while a result is pending")

endmodule

// ----- hdl/tx_ring_packet_framer_dma.sv -----
// Top level of the transmit ring with packet framing and DMA chunk control.
`timescale 1ns / 1ps

// Transmit byte ring of 8192 bytes with packet framing and DMA chunk control.
// The front accepts one item per cycle whenever its two-entry queue has room;
// it checks space and sequence, updates the head and tail pointers and decides
// DMA launches right away. The back drains the queue through the single write
// port of the ring memory: put byte, payload byte and non-memory items load
// their result as soon as the output register is free, a fetch passes
// through a result state for the registered memory read, and a packet begin
// writes six header bytes one per cycle and then gives its result. Each item
// yields one result, held in an output register. While a result is stalled
// there, the back may still write header bytes, but the next result waits
// until the register is taken. The ring memory is not cleared after reset;
// fetching a location that was never written returns garbage.
module tx_ring_packet_framer_dma #(
    parameter int MAX_CHUNK = 65535
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  command,
    input  logic [7:0]                  data_byte,
    input  logic [trpf_pkg::LEN_W-1:0]  packet_length,
    input  logic [7:0]                  socket_id,
    input  logic [trpf_pkg::ADDR_W-1:0] fetch_address,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [trpf_pkg::CNT_W-1:0]  free_space,
    output logic                        dma_start,
    output logic [trpf_pkg::ADDR_W-1:0] dma_offset,
    output logic [trpf_pkg::CNT_W-1:0]  dma_length,
    output logic [7:0]                  fetch_data,
    output logic                        transferring
);

    import trpf_pkg::*;

    logic    q_full;
    logic    q_push;
    logic    q_pop;
    logic    q_nonempty;
    entry_t  push_entry;
    entry_t  head_entry;
    result_t out_res;

    trpf_front #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .data_byte     (data_byte),
        .packet_length (packet_length),
        .socket_id     (socket_id),
        .fetch_address (fetch_address),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (push_entry)
    );

    trpf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .nonempty   (q_nonempty),
        .head_entry (head_entry)
    );

    trpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_entry    (head_entry),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_res    (out_res),
        .out_fetch  (fetch_data)
    );

    // Spread the result register onto the ports
    assign status       = out_res.status;
    assign free_space   = out_res.free_space;
    assign dma_start    = out_res.dma_start;
    assign dma_offset   = out_res.dma_offset;
    assign dma_length   = out_res.dma_length;
    assign transferring = out_res.transferring;

endmodule

// ----- dv/tb_tx_ring_packet_framer_dma.sv -----
// Self-checking testbench for the transmit ring framer with DMA chunk control.
`timescale 1ns / 1ps

module tb_tx_ring_packet_framer_dma;

    import trpf_pkg::*;

    localparam int MAX_CHUNK = 65535;
    localparam int RANDOM_ITEMS = 720;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int MAX_WAIT = 12;
    localparam int TAIL_CYCLES = 16;
    localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [2:0] CMD_RSVD_LAST = 3'd7;

    typedef struct packed {
        logic [1:0]        status;
        logic [CNT_W-1:0]  free_space;
        logic              dma_start;
        logic [ADDR_W-1:0] dma_offset;
        logic [CNT_W-1:0]  dma_length;
        logic [7:0]        fetch_data;
        logic              transferring;
    } ring_result_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [2:0]        command;
    logic [7:0]        data_byte;
    logic [LEN_W-1:0]  packet_length;
    logic [7:0]        socket_id;
    logic [ADDR_W-1:0] fetch_address;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        status;
    logic [CNT_W-1:0]  free_space;
    logic              dma_start;
    logic [ADDR_W-1:0] dma_offset;
    logic [CNT_W-1:0]  dma_length;
    logic [7:0]        fetch_data;
    logic              transferring;

    // Shadow copy of the ring state
    logic [7:0]        ring_mem [RING_BYTES];
    bit                written [RING_BYTES];
    bit                any_written;
    logic [ADDR_W-1:0] head_ptr;
    logic [ADDR_W-1:0] tail_ptr;
    logic [CNT_W-1:0]  chunk_len;
    logic              dma_busy;
    logic [LEN_W-1:0]  pkt_left;
    logic [1:0]        last_status;

    ring_result_t      expected_results [$];
    int                mismatch_count;
    int                live_items;
    int                cycle_count;
    int                rx_hold;
    bit                quiet_mode;

    tx_ring_packet_framer_dma #(
        .MAX_CHUNK(MAX_CHUNK)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .data_byte(data_byte),
        .packet_length(packet_length),
        .socket_id(socket_id),
        .fetch_address(fetch_address),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .free_space(free_space),
        .dma_start(dma_start),
        .dma_offset(dma_offset),
        .dma_length(dma_length),
        .fetch_data(fetch_data),
        .transferring(transferring)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int idle_draw();
        return quiet_mode ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic int ring_free();
        if (head_ptr < tail_ptr)
        begin
            return int'(tail_ptr) - int'(head_ptr);
        end
        return RING_BYTES - (int'(head_ptr) - int'(tail_ptr));
    endfunction

    task automatic ring_push(input logic [7:0] b);
        ring_mem[head_ptr] = b;
        written[head_ptr] = 1'b1;
        any_written = 1'b1;
        head_ptr = head_ptr + 1'b1;
    endtask

    // Launch a chunk from the tail to the head, or to the ring end on wrap
    task automatic chunk_launch(inout ring_result_t r);
        int len;
        if (head_ptr >= tail_ptr)
        begin
            len = int'(head_ptr) - int'(tail_ptr);
        end
        else
        begin
            len = RING_BYTES - int'(tail_ptr);
        end
        if (len > MAX_CHUNK)
        begin
            len = MAX_CHUNK;
        end
        chunk_len = CNT_W'(len);
        dma_busy = 1'b1;
        r.dma_start = 1'b1;
        r.dma_offset = tail_ptr;
        r.dma_length = CNT_W'(len);
    endtask

    // Work out the result of one accepted item and queue it
    task automatic ring_predict(input logic [2:0] cmd, input logic [7:0] db,
                                input logic [LEN_W-1:0] plen, input logic [7:0] sock,
                                input logic [ADDR_W-1:0] faddr);
        ring_result_t r;
        int nxt;
        r = '0;
        r.status = STS_OK;
        case (cmd)
            CMD_PUT:
            begin
                if (pkt_left != 0)
                begin
                    r.status = STS_SEQ;
                end
                else if (ring_free() <= 2)
                begin
                    r.status = STS_NOSPACE;
                end
                else
                begin
                    ring_push(db);
                    if (!dma_busy)
                    begin
                        chunk_launch(r);
                    end
                end
            end
            CMD_BEGIN:
            begin
                if (pkt_left != 0)
                begin
                    r.status = STS_SEQ;
                end
                else if (ring_free() <= int'(plen) + 9)
                begin
                    r.status = STS_NOSPACE;
                end
                else
                begin
                    ring_push(HDR_MAGIC_0);
                    ring_push(HDR_MAGIC_1);
                    ring_push(plen[7:0]);
                    ring_push(plen[15:8]);
                    ring_push(8'h00);
                    ring_push(sock);
                    pkt_left = plen;
                    if (plen == 0 && !dma_busy)
                    begin
                        chunk_launch(r);
                    end
                end
            end
            CMD_PAYLOAD:
            begin
                if (pkt_left == 0)
                begin
                    r.status = STS_SEQ;
                end
                else
                begin
                    ring_push(db);
                    pkt_left = pkt_left - 1'b1;
                    if (pkt_left == 0 && !dma_busy)
                    begin
                        chunk_launch(r);
                    end
                end
            end
            CMD_DONE:
            begin
                if (!dma_busy)
                begin
                    r.status = STS_SEQ;
                end
                else
                begin
                    nxt = int'(tail_ptr) + int'(chunk_len);
                    if (nxt >= RING_BYTES)
                    begin
                        nxt = 0;
                    end
                    tail_ptr = ADDR_W'(nxt);
                    if (head_ptr != tail_ptr)
                    begin
                        chunk_launch(r);
                    end
                    else
                    begin
                        dma_busy = 1'b0;
                        chunk_len = '0;
                    end
                end
            end
            CMD_FETCH:
            begin
                r.fetch_data = ring_mem[faddr];
            end
            default:
            begin
                r.status = STS_SEQ;
            end
        endcase
        r.free_space = CNT_W'(ring_free());
        r.transferring = dma_busy;
        last_status = r.status;
        expected_results.push_back(r);
    endtask

    // Drive one item at the falling edge and hold it until accepted
    task automatic send_item(input logic [2:0] cmd, input logic [7:0] db,
                             input logic [LEN_W-1:0] plen, input logic [7:0] sock,
                             input logic [ADDR_W-1:0] faddr);
        int gap;
        if ($urandom_range(0, 199) == 0)
        begin
            quiet_mode = !quiet_mode;
        end
        gap = idle_draw();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        command = cmd;
        data_byte = db;
        packet_length = plen;
        socket_id = sock;
        fetch_address = faddr;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        ring_predict(cmd, db, plen, sock, faddr);
        if (last_status != STS_SEQ)
        begin
            live_items++;
        end
        @(negedge clk);
    endtask

    task automatic send_simple(input logic [2:0] cmd, input logic [7:0] db);
        send_item(cmd, db, 16'($urandom), 8'($urandom), 13'($urandom));
    endtask

    task automatic send_fetch(input logic [ADDR_W-1:0] addr);
        send_item(CMD_FETCH, 8'($urandom), 16'($urandom), 8'($urandom), addr);
    endtask

    // Pick an address that has been written, so fetches never read garbage
    function automatic logic [ADDR_W-1:0] pick_fetch_addr();
        logic [ADDR_W-1:0] a;
        for (int i = 0; i < 32; i++)
        begin
            a = ADDR_W'($urandom);
            if (written[a])
            begin
                return a;
            end
        end
        return head_ptr - 1'b1;
    endfunction

    // Send a random command of any kind, valid or not
    task automatic send_random_other();
        case ($urandom_range(0, 5))
            0: send_simple(CMD_PUT, 8'($urandom));
            1: send_item(CMD_BEGIN, 8'($urandom), 16'($urandom) | 16'h2000,
                         8'($urandom), 13'($urandom));
            2: send_simple(CMD_DONE, 8'($urandom));
            3:
            begin
                if (any_written)
                begin
                    send_fetch(pick_fetch_addr());
                end
                else
                begin
                    send_simple(CMD_DONE, 8'($urandom));
                end
            end
            4: send_simple(CMD_PAYLOAD, 8'($urandom));
            default: send_simple(3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST)),
                                 8'($urandom));
        endcase
    endtask

    // Open a packet and feed its payload, with optional interlopers
    task automatic send_packet(input logic [LEN_W-1:0] len, input bit noisy);
        send_item(CMD_BEGIN, 8'($urandom), len, 8'($urandom), 13'($urandom));
        while (pkt_left != 0)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
            begin
                send_random_other();
            end
            else
            begin
                send_simple(CMD_PAYLOAD, 8'($urandom));
            end
        end
    endtask

    // Retire chunks until the DMA side goes idle
    task automatic drain_chunks();
        while (dma_busy)
        begin
            send_simple(CMD_DONE, 8'($urandom));
        end
    endtask

    task automatic test_stray_commands();
        send_item(CMD_DONE, 8'h00, 16'h0000, 8'h00, 13'h0000);
        send_item(CMD_PAYLOAD, 8'hFF, 16'hFFFF, 8'hFF, 13'h1FFF);
        for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++)
        begin
            send_simple(3'(c), 8'($urandom));
        end
    endtask

    task automatic test_put_and_dma();
        send_simple(CMD_PUT, 8'h00);
        send_simple(CMD_PUT, 8'hFF);
        send_fetch(13'h0000);
        send_fetch(13'h0001);
        send_simple(CMD_DONE, 8'h00);
        send_simple(CMD_DONE, 8'h00);
        send_simple(CMD_DONE, 8'h00);
    endtask

    task automatic test_packet_framing();
        // too long for any ring state
        send_item(CMD_BEGIN, 8'hFF, 16'hFFFF, 8'hFF, 13'h1FFF);
        // zero-length packet completes at begin
        send_item(CMD_BEGIN, 8'h00, 16'd0, 8'hA5, 13'h0000);
        send_item(CMD_BEGIN, 8'h00, 16'd3, 8'hFF, 13'h0000);
        // out of sequence while the packet is open
        send_simple(CMD_PUT, 8'h11);
        send_item(CMD_BEGIN, 8'h00, 16'd1, 8'h00, 13'h0000);
        send_simple(CMD_PAYLOAD, 8'h00);
        // retire during the packet, next chunk carries part of it
        send_simple(CMD_DONE, 8'h00);
        send_simple(CMD_PAYLOAD, 8'hFF);
        send_simple(CMD_PAYLOAD, 8'h5A);
        send_fetch(head_ptr - 13'd9);
        send_fetch(head_ptr - 13'd4);
        drain_chunks();
    endtask

    task automatic test_space_boundary();
        drain_chunks();
        send_packet(16'd40, 1'b0);
        // exactly the free space a packet of this length may not have
        send_item(CMD_BEGIN, 8'($urandom), LEN_W'(ring_free() - 9), 8'($urandom),
                  13'($urandom));
        repeat (10)
        begin
            send_fetch(pick_fetch_addr());
        end
        drain_chunks();
    endtask

    task automatic test_random_traffic();
        int goal;
        int pick;
        int sel;
        goal = live_items + RANDOM_ITEMS;
        while (live_items < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pkt_left != 0)
            begin
                send_simple(CMD_PAYLOAD, 8'($urandom));
            end
            else if (pick < 40)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 80)
                begin
                    send_packet(16'($urandom_range(0, 24)), $urandom_range(0, 3) == 0);
                end
                else if (sel < 95)
                begin
                    send_packet(16'($urandom_range(25, 300)), $urandom_range(0, 3) == 0);
                end
                else
                begin
                    send_packet(16'($urandom) | 16'h2000, 1'b0);
                end
            end
            else if (pick < 55)
            begin
                send_simple(CMD_PUT, 8'($urandom));
            end
            else if (pick < 72)
            begin
                send_simple(CMD_DONE, 8'($urandom));
            end
            else if (pick < 85)
            begin
                if (any_written)
                begin
                    send_fetch(pick_fetch_addr());
                end
                else
                begin
                    send_simple(CMD_PUT, 8'($urandom));
                end
            end
            else
            begin
                send_random_other();
            end
        end
    endtask

    // Compare one field, treating unknown bits as a mismatch
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Stall the result side for the drawn number of cycles
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_stall = 1'b1;
                rx_hold--;
            end
            else
            begin
                out_stall = 1'b0;
            end
        end
    end

    // Check each accepted result against the oldest expectation
    initial
    begin
        ring_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, status);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("free_space", want.free_space, free_space);
                    check_field("dma_start", want.dma_start, dma_start);
                    check_field("dma_offset", want.dma_offset, dma_offset);
                    check_field("dma_length", want.dma_length, dma_length);
                    check_field("fetch_data", want.fetch_data, fetch_data);
                    check_field("transferring", want.transferring, transferring);
                end
                rx_hold = idle_draw();
            end
        end
    end

    // Abort a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_PUT;
        data_byte = '0;
        packet_length = '0;
        socket_id = '0;
        fetch_address = '0;
        head_ptr = '0;
        tail_ptr = '0;
        chunk_len = '0;
        dma_busy = 1'b0;
        pkt_left = '0;
        last_status = STS_OK;
        any_written = 1'b0;
        mismatch_count = 0;
        live_items = 0;
        rx_hold = 0;
        quiet_mode = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_stray_commands();
        test_put_and_dma();
        test_packet_framing();
        test_space_boundary();
        test_random_traffic();

        // Let the last results drain, then allow for the pipeline
        in_valid = 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
